// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the walking pattern scan RTL.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define WPCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
`define WPCS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define WPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define WPCS_ASSERT(lbl, clk, rst, prop)
`define WPCS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define WPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/wpcs_pkg.sv =====
// Shared constants, types and walk-step helpers for the walking pattern scan.
// No dependencies.
`default_nettype none

package wpcs_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_WALK   = 32;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = $clog2(MAX_COLS + 1);
  localparam int PFX_W      = $clog2(MAX_WALK);
  localparam int LEN_W      = 6;
  localparam int VAL_W      = 32;
  localparam int DIR_W      = 31;
  localparam int COLS_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CMP_W      = (PFX_W + 1 > LEN_W) ? PFX_W + 1 : LEN_W;

  typedef logic [PFX_W-1:0] pfx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALK_LENGTH     = 3'd0,
    REG_WALK_VALUES     = 3'd1,
    REG_WALK_DIRECTIONS = 3'd2,
    REG_MATRIX_COLS     = 3'd3,
    REG_ROW_ORDER       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] walk_length;
    logic [VAL_W-1:0] walk_values;
    logic [DIR_W-1:0] walk_directions;
    logic [CNT_W-1:0] cols_eff;
  } wpcs_cfg_t;

  typedef struct packed {
    logic match;
    pfx_t nv;
    pfx_t nh;
  } step_res_t;

  // Value bit of walk step p; steps beyond the register read as 0
  function automatic logic walk_value_bit(input logic [VAL_W-1:0] word, input pfx_t p);
    logic [VAL_W-1:0] sh;
    sh = word >> p;
    return sh[0];
  endfunction

  // Direction bit of walk step p; steps beyond the register read as 0
  function automatic logic walk_dir_bit(input logic [DIR_W-1:0] word, input pfx_t p);
    logic [DIR_W-1:0] sh;
    sh = word >> p;
    return sh[0];
  endfunction

  // True when extending prefix p completes a walk of length len
  function automatic logic walk_done(input pfx_t p, input logic [LEN_W-1:0] len);
    logic [CMP_W-1:0] p1;
    logic [CMP_W-1:0] l;
    p1 = CMP_W'(p) + CMP_W'(1);
    l  = CMP_W'(len);
    return (p1 == l) && (l <= CMP_W'(MAX_WALK));
  endfunction

  // Prefix plus one, held at the top step
  function automatic pfx_t sat_inc(input pfx_t p);
    return (p == pfx_t'(MAX_WALK - 1)) ? p : p + pfx_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wpcs_cfg_regs.sv =====
// Configuration register file of the walking pattern scan.
// Depends on wpcs_pkg.
`default_nettype none

module wpcs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wpcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output wpcs_pkg::wpcs_cfg_t                 cfg
);
  import wpcs_pkg::*;

  logic [LEN_W-1:0]  walk_length;
  logic [VAL_W-1:0]  walk_values;
  logic [DIR_W-1:0]  walk_directions;
  logic [COLS_W-1:0] matrix_cols;
  logic              cfg_fire;

  // Always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Decode the register index and latch the data
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_length     <= LEN_W'(2);
      walk_values     <= VAL_W'(3);
      walk_directions <= '0;
      matrix_cols     <= COLS_W'(MAX_COLS);
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WALK_LENGTH:     walk_length     <= cfg_data[LEN_W-1:0];
        REG_WALK_VALUES:     walk_values     <= cfg_data[VAL_W-1:0];
        REG_WALK_DIRECTIONS: walk_directions <= cfg_data[DIR_W-1:0];
        REG_MATRIX_COLS:     matrix_cols     <= cfg_data[COLS_W-1:0];
        // Row order only tells how the host feeds rows; no storage needed
        REG_ROW_ORDER:       ;
        default:             ;
      endcase
    end
  end

  // Fold an out-of-range column count onto the full width
  always_comb begin
    cfg.walk_length     = walk_length;
    cfg.walk_values     = walk_values;
    cfg.walk_directions = walk_directions;
    if (matrix_cols == '0 || CNT_W'(matrix_cols) > CNT_W'(MAX_COLS)) begin
      cfg.cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cfg.cols_eff = CNT_W'(matrix_cols);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wpcs_col_store.sv =====
// Per-column vertical prefix memory with registered read and write bypass.
// Depends on wpcs_pkg.
`default_nettype none

module wpcs_col_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [wpcs_pkg::COL_W-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [wpcs_pkg::COL_W-1:0] wr_addr,
  input  wpcs_pkg::pfx_t           wr_data,
  output wpcs_pkg::pfx_t           rd_data
);
  import wpcs_pkg::*;

  pfx_t mem [MAX_COLS];
  pfx_t mem_rdata;
  logic byp;
  pfx_t byp_data;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rdata <= mem[rd_addr];
      byp_data  <= wr_data;
    end
  end

  // Catch a write to the address being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : mem_rdata;

endmodule

`default_nettype wire

// ===== rtl/wpcs_step.sv =====
// Cell update of the walking pattern scan: extends the vertical and
// horizontal prefixes of one cell. Depends on wpcs_pkg.
`default_nettype none

module wpcs_step (
  input  wpcs_pkg::wpcs_cfg_t cfg,
  input  logic                cell_value,
  input  wpcs_pkg::pfx_t      vp,
  input  wpcs_pkg::pfx_t      hp,
  output wpcs_pkg::step_res_t res
);
  import wpcs_pkg::*;

  logic ok_v, ok_h, done_v, done_h, side_v, side_h;
  pfx_t next_v, next_h;

  // Decide per prefix whether the cell may extend it and where it goes
  always_comb begin
    ok_v   = cell_value || !walk_value_bit(cfg.walk_values, vp);
    ok_h   = cell_value || !walk_value_bit(cfg.walk_values, hp);
    done_v = ok_v && walk_done(vp, cfg.walk_length);
    done_h = ok_h && walk_done(hp, cfg.walk_length);
    side_v = walk_dir_bit(cfg.walk_directions, vp);
    side_h = walk_dir_bit(cfg.walk_directions, hp);
    next_v = sat_inc(vp);
    next_h = sat_inc(hp);
  end

  // Take the larger candidate for each direction
  always_comb begin
    res.match = done_v || done_h;
    res.nv    = vp;
    res.nh    = hp;
    if (ok_v && !side_v && next_v > res.nv) res.nv = next_v;
    if (ok_v &&  side_v && next_v > res.nh) res.nh = next_v;
    if (ok_h && !side_h && next_h > res.nv) res.nv = next_h;
    if (ok_h &&  side_h && next_h > res.nh) res.nh = next_h;
  end

endmodule

`default_nettype wire

// ===== rtl/walking_pattern_containment_scan_top.sv =====
// Walking pattern containment scan: top level with the two-stage pipeline.
// Depends on wpcs_pkg, wpcs_cfg_regs, wpcs_col_store, wpcs_step, assert_macros.svh.
//
// Usage:
//   Write the walk (length, values, directions) and the column count on the
//   cfg channel while the block is idle. Then feed the matrix one bit per
//   transaction on the input channel in raster order, with final_cell high
//   on the last bit. Each matrix gives one transaction on the output channel:
//   contains_pattern is 1 if the walk occurs in the matrix.
//   Throughput is one cell per cycle unless a final cell is held. A cell is
//   accepted, the column store is read at that same edge, and the cell is
//   updated in the following cycle; the final cell's result is then registered.
//   The rate is set by the column store read-modify-write loop, which uses
//   a write-to-read bypass when consecutive cells hit the same column.
//   If the receiver stalls, the result waits in the output register and
//   cells keep flowing; only the next final cell waits in the update stage,
//   and input ready drops behind it. Reset restores the default walk and
//   starts a fresh matrix; the column store needs no clearing, since the
//   first row ignores what it reads.
`default_nettype none

`include "assert_macros.svh"

module walking_pattern_containment_scan_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cell_bit,
  input  logic                             final_cell,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             contains_pattern,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wpcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wpcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wpcs_pkg::*;

  wpcs_cfg_t  cfg;
  step_res_t  res;

  logic              in_fire;
  logic [COL_W-1:0]  column_position;
  logic              first_row;
  logic              pos_wrap;

  logic              s1_valid;
  logic              s1_cell;
  logic              s1_last;
  logic [COL_W-1:0]  s1_pos;
  logic              s1_first;
  logic              s1_fire;

  logic              found;
  pfx_t              row_prefix;
  pfx_t              vp_raw;
  pfx_t              vp;
  pfx_t              hp;
  logic              wr_en;

  wpcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: take a cell whenever the update stage is free or moving on
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign pos_wrap = (CNT_W'(column_position) + CNT_W'(1)) >= cfg.cols_eff;

  // Advance the column position and first-row flag on each accepted cell
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      first_row       <= 1'b1;
    end else if (in_fire) begin
      if (final_cell) begin
        column_position <= '0;
        first_row       <= 1'b1;
      end else if (pos_wrap) begin
        column_position <= '0;
        first_row       <= 1'b0;
      end else begin
        column_position <= column_position + COL_W'(1);
      end
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell  <= cell_bit;
      s1_last  <= final_cell;
      s1_pos   <= column_position;
      s1_first <= first_row;
    end
  end

  wpcs_col_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (column_position),
    .wr_en   (wr_en),
    .wr_addr (s1_pos),
    .wr_data (res.nv),
    .rd_data (vp_raw)
  );

  // Select the incoming prefixes; first row and first column start empty
  assign vp = s1_first ? '0 : vp_raw;
  assign hp = (s1_pos == '0) ? '0 : row_prefix;

  wpcs_step u_step (
    .cfg        (cfg),
    .cell_value (s1_cell),
    .vp         (vp),
    .hp         (hp),
    .res        (res)
  );

  // Write back only while no match has been seen
  assign wr_en = s1_fire && !found && !res.match;

  // Sticky found flag, dropped at the end of each matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        found <= 1'b0;
      end else if (res.match) begin
        found <= 1'b1;
      end
    end
  end

  // Horizontal prefix handed to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      row_prefix <= '0;
    end else if (wr_en) begin
      row_prefix <= res.nh;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      contains_pattern <= found || res.match;
    end
  end

  // Checks
  `WPCS_ASSERT_NEXT(a_bypass, clk, rst, in_fire && wr_en && (s1_pos == column_position), vp_raw == $past(res.nv))
  `WPCS_ASSERT_IMPL(a_no_write_after_found, clk, rst, wr_en, !found)
  `WPCS_ASSERT_IMPL(a_last_stall_blocks, clk, rst, s1_valid && !s1_fire, !in_ready)
  `WPCS_ASSERT_NEXT(a_restart, clk, rst, in_fire && final_cell, first_row && (column_position == '0))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for walking_pattern_containment_scan_top: feeds binary matrices under many walk
// settings, predicts each containment result in a local scan model and checks it.
// Depends on wpcs_pkg and the walking pattern scan RTL.
module testbench;
  import wpcs_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;
  typedef struct packed {
    logic bit_val;
    logic last;
  } cell_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cell_bit = 1'b0;
  logic                  final_cell = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  contains_pattern;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Scan model: register copies and per-matrix state
  logic [LEN_W-1:0]  walk_len = 6'd2;
  logic [VAL_W-1:0]  walk_val = 32'd3;
  logic [DIR_W-1:0]  walk_dir = '0;
  logic [COLS_W-1:0] col_count = 11'd1024;
  logic              rows_mirrored = 1'b0;
  bit [4:0]          vert_pfx [MAX_COLS];
  bit [4:0]          horz_pfx = '0;
  int                col_pos = 0;
  bit                top_row = 1'b1;
  bit                matched = 1'b0;

  cell_t cell_queue [$];
  bit    pattern_due [$];
  int    queued_cells = 0;
  int    accepted_cells = 0;
  int    mismatches = 0;
  int    quiet = 0;
  int    walk_down = 0;
  int    walk_side = 0;
  bit    in_taken = 1'b0;
  bit    cfg_taken = 1'b0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  flow_t flow = FLOW_FREE;

  walking_pattern_containment_scan_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cell_bit         (cell_bit),
    .final_cell       (final_cell),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .contains_pattern (contains_pattern),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Extend prefix p at this cell; true when the walk completes
  function automatic bit try_extend(input int p, input bit cbit, inout int nv, inout int nh);
    int step_up;
    if (!cbit && walk_val[p]) return 1'b0;
    if (p + 1 == int'(walk_len) && walk_len <= MAX_WALK) return 1'b1;
    step_up = (p + 1 > MAX_WALK - 1) ? MAX_WALK - 1 : p + 1;
    if (p < DIR_W && walk_dir[p]) begin
      if (nh < step_up) nh = step_up;
    end else begin
      if (nv < step_up) nv = step_up;
    end
    return 1'b0;
  endfunction

  // Advance the scan by one cell; true when the cell ends a matrix, with its verdict in hit
  function automatic bit scan_cell(input bit cbit, input bit last, output bit hit);
    int cols, pos, vp, hp, nv, nh;
    cols = col_count;
    if (cols == 0 || cols > MAX_COLS) cols = MAX_COLS;
    pos = col_pos % MAX_COLS;
    vp = top_row ? 0 : int'(vert_pfx[pos]);
    hp = (pos == 0) ? 0 : int'(horz_pfx);
    if (!matched) begin
      nv = vp;
      nh = hp;
      if (try_extend(vp, cbit, nv, nh)) matched = 1'b1;
      else if (try_extend(hp, cbit, nv, nh)) matched = 1'b1;
      if (!matched) begin
        vert_pfx[pos] = nv[4:0];
        horz_pfx = nh[4:0];
      end
    end
    // Wrap to the next row
    if (pos + 1 >= cols) begin
      col_pos = 0;
      top_row = 1'b0;
      horz_pfx = '0;
    end else begin
      col_pos = pos + 1;
    end
    hit = matched;
    if (last) begin
      horz_pfx = '0;
      col_pos = 0;
      top_row = 1'b1;
      matched = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drive the next cell once the previous transaction has gone through
  always @(negedge clk) begin : cell_driver
    cell_t nxt;
    int gap;
    gap = (flow == FLOW_SEND_GAPS) ? 57 : (flow == FLOW_BOTH) ? 31 : 0;
    if (!rst && (!in_valid || in_taken)) begin
      if (cell_queue.size() != 0 && !chance(gap)) begin
        nxt = cell_queue.pop_front();
        in_valid <= 1'b1;
        cell_bit <= nxt.bit_val;
        final_cell <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off
  always @(negedge clk) begin : result_sink
    int stall;
    stall = (flow == FLOW_RECV_STALLS) ? 57 : (flow == FLOW_BOTH) ? 31 : 0;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !chance(stall);
    end
  end

  // Track every transaction: register writes, cells and results
  always @(posedge clk) begin : scoreboard
    bit hit;
    bit want;
    in_taken = in_valid && in_ready;
    cfg_taken = cfg_valid && cfg_ready;
    if (cfg_taken) begin
      case (cfg_index)
        REG_WALK_LENGTH:     walk_len = cfg_data[LEN_W-1:0];
        REG_WALK_VALUES:     walk_val = cfg_data[VAL_W-1:0];
        REG_WALK_DIRECTIONS: walk_dir = cfg_data[DIR_W-1:0];
        REG_MATRIX_COLS:     col_count = cfg_data[COLS_W-1:0];
        REG_ROW_ORDER:       rows_mirrored = cfg_data[0];
        default: ;
      endcase
    end
    if (in_taken) begin
      accepted_cells++;
      if (scan_cell(cell_bit, final_cell, hit)) pattern_due.push_back(hit);
    end
    if (!rst && out_valid && out_ready) begin
      if (pattern_due.size() == 0) begin
        mismatches++;
        $error("contains_pattern: expected no result, got %0b", contains_pattern);
      end else begin
        want = pattern_due.pop_front();
        if (contains_pattern !== want) begin
          mismatches++;
          $error("contains_pattern: expected %0b, got %0b", want, contains_pattern);
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every cell is taken and every verdict is back
  task automatic drain(input int extra);
    while (accepted_cells != queued_cells || pattern_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Queue a matrix given as bits in feed order, lowest bit first
  task automatic add_cells(input logic [31:0] bits, input int n);
    for (int k = 0; k < n; k++) cell_queue.push_back(cell_t'{bits[k], k == n - 1});
    queued_cells += n;
  endtask

  // Queue a random matrix, optionally with the walk planted at a random origin.
  // Coordinates are in feed order, so with mirrored rows the walk lands mirrored.
  task automatic add_matrix(input int rows, input int cols, input int ncells, input int dens,
                            input bit plant);
    bit grid [MAX_COLS];
    int r, c, k;
    for (k = 0; k < ncells; k++) grid[k] = chance(dens);
    if (plant) begin
      r = $urandom_range(0, rows - 1 - walk_down);
      c = $urandom_range(0, cols - 1 - walk_side);
      for (k = 0; k < walk_len; k++) begin
        if (walk_val[k] && r * cols + c < ncells) grid[r * cols + c] = 1'b1;
        if (k + 1 < walk_len) begin
          if (walk_dir[k]) c++;
          else r++;
        end
      end
    end
    for (k = 0; k < ncells; k++) cell_queue.push_back(cell_t'{grid[k], k == ncells - 1});
    queued_cells += ncells;
  endtask

  initial begin : stimulus
    int mark, phase_mark, rows, cols, ncells, sel, pick, k;
    bit plant, wide, walk_ok;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset walk goes straight down, so a single row misses it
    add_cells(32'b011, 3);
    drain(SETTLE_CYCLES);
    // Zero length never matches; this row also writes columns 0..31 of the store
    write_reg(REG_WALK_LENGTH, 32'd0);
    write_reg(REG_MATRIX_COLS, 32'd32);
    add_cells(32'hFFFF_FFFF, 32);
    drain(SETTLE_CYCLES);
    // One-step walk on a one-column matrix
    write_reg(REG_WALK_LENGTH, 32'd1);
    write_reg(REG_WALK_VALUES, 32'hFFFF_FFFF);
    write_reg(REG_MATRIX_COLS, 32'd1);
    add_cells(32'b0, 1);
    add_cells(32'b1, 1);
    drain(SETTLE_CYCLES);
    // Zero-valued step matches on the first cell, the rest is scanned after the hit
    write_reg(REG_WALK_VALUES, 32'd0);
    write_reg(REG_MATRIX_COLS, 32'd2);
    add_cells(32'b0000, 4);
    drain(SETTLE_CYCLES);
    // Three steps sideways: one row hits, one misses
    write_reg(REG_WALK_LENGTH, 32'd3);
    write_reg(REG_WALK_VALUES, 32'd7);
    write_reg(REG_WALK_DIRECTIONS, 32'd3);
    write_reg(REG_MATRIX_COLS, 32'd4);
    add_cells(32'b1110, 4);
    add_cells(32'b1011, 4);
    drain(SETTLE_CYCLES);
    // Three steps down one column, rows fed mirrored
    write_reg(REG_WALK_DIRECTIONS, 32'd0);
    write_reg(REG_MATRIX_COLS, 32'd2);
    write_reg(REG_ROW_ORDER, 32'd1);
    add_cells(32'b101010, 6);
    drain(SETTLE_CYCLES);

    mark = queued_cells;
    for (int ph = 0; queued_cells - mark < 1400; ph++) begin
      flow = flow_t'(ph % 4);

      // Pick a walk length: full length and out of range come first
      sel = (ph < 4) ? ph : $urandom_range(19);
      if (sel == 0) pick = MAX_WALK;
      else if (sel == 1) pick = chance(50) ? 0 : $urandom_range(33, 63);
      else if (sel < 5) pick = $urandom_range(7, 31);
      else pick = $urandom_range(1, 6);
      write_reg(REG_WALK_LENGTH, 32'(pick));

      sel = $urandom_range(9);
      write_reg(REG_WALK_VALUES, (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom);
      sel = $urandom_range(9);
      write_reg(REG_WALK_DIRECTIONS,
                (sel == 0) ? 32'd0 : (sel == 1) ? 32'h7FFF_FFFF : ($urandom & 32'h7FFF_FFFF));

      // Column count: mostly narrow, now and then wide or out of range
      walk_ok = walk_len >= 1 && walk_len <= MAX_WALK;
      if (ph == 4 || ph == 6 || chance(12)) begin
        sel = $urandom_range(3);
        if (sel == 0) pick = 0;
        else if (sel == 1) pick = MAX_COLS;
        else if (sel == 2) pick = $urandom_range(MAX_COLS + 1, 2047);
        else pick = $urandom_range(33, MAX_COLS - 1);
      end else begin
        pick = (walk_ok && walk_len <= 8) ? $urandom_range(1, 12) : $urandom_range(8, 32);
      end
      write_reg(REG_MATRIX_COLS, 32'(pick));
      write_reg(REG_ROW_ORDER, 32'($urandom_range(1)));

      cols = (col_count == 0 || col_count > MAX_COLS) ? MAX_COLS : int'(col_count);
      wide = cols > 32;
      walk_down = 0;
      walk_side = 0;
      for (k = 0; k + 1 < walk_len && k < DIR_W; k++) begin
        if (walk_dir[k]) walk_side++;
        else walk_down++;
      end

      // Fill the block while the result side holds off
      if (ph == 2) begin
        hold_req = 1'b1;
        repeat (15) add_matrix(3, cols, $urandom_range(1, 3), 50, 1'b0);
      end

      phase_mark = queued_cells;
      while (queued_cells - phase_mark < 100) begin
        plant = walk_ok && chance(60) && walk_side < cols;
        if (wide) begin
          // Wide matrices stay within their first row
          rows = 1;
          plant = plant && walk_down == 0;
          ncells = $urandom_range(1, (cols < 60) ? cols : 60);
        end else begin
          rows = $urandom_range(1, 1 + 72 / cols);
          if (plant && rows <= walk_down) rows = walk_down + 1;
          ncells = chance(80) ? rows * cols : $urandom_range(1, rows * cols);
        end
        add_matrix(rows, cols, ncells, $urandom_range(0, 100), plant);
        if (chance(8)) drain(0);
      end
      drain(SETTLE_CYCLES);
    end

    drain(8);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
